FILE: design/ndpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndpc_pkg
// Shared sizes and the command code for the near-duplicate point counter.
// ----------------------------------------------------------------------------
package ndpc_pkg;
   localparam int MaxPoints = 4096;
   localparam int AddrBits = $clog2(MaxPoints);
   localparam int CntBits = AddrBits + 1;
   localparam int CoordBits = 32;
   localparam int TolBits = 31;
   localparam int PairBits = 23;
   localparam int OutCntBits = 13;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } cmd_type;

   // Point coordinates held offset-binary, so unsigned order is signed order.
   typedef struct packed {
      logic [CoordBits-1:0] x;
      logic [CoordBits-1:0] y;
      logic [CoordBits-1:0] z;
   } point_type;

   function automatic logic [CoordBits-1:0] to_biased(input logic [CoordBits-1:0] raw);
      to_biased = raw ^ {1'b1, {(CoordBits-1){1'b0}}};
   endfunction
endpackage
`default_nettype wire

FILE: design/ndpc_point_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndpc_point_ram
// Point store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ndpc_point_ram (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ndpc_pkg::AddrBits-1:0] wr_addr,
   input  wire ndpc_pkg::point_type      wr_data,
   input  wire logic [ndpc_pkg::AddrBits-1:0] rd_addr_a,
   output ndpc_pkg::point_type           rd_data_a,
   input  wire logic [ndpc_pkg::AddrBits-1:0] rd_addr_b,
   output ndpc_pkg::point_type           rd_data_b
);
   import ndpc_pkg::*;

   point_type mem [MaxPoints];
   point_type rd_a_ff;
   point_type rd_b_ff;

   // Write, and register both reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule
`default_nettype wire

FILE: design/near_duplicate_point_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// near_duplicate_point_counter
// Counts point pairs that agree on all three axes within a tolerance.
// ----------------------------------------------------------------------------
// A load word leaves busy low, and the next word may follow at once. An
// evaluate word raises busy until its result strobe. It first clears the mark
// bits of the n loaded points, one per cycle. It then compares every unordered
// pair of points through the two read ports of the point store, one pair per
// cycle, and counts a point as a vertex once its last pair is scored. For n of
// at least two the pair pass is followed by the drain, read and last states,
// which score the last point, and then the done state; for fewer points the
// done state follows the clear pass. Busy drops in the strobe cycle, so the
// next word can be taken at the edge that ends it. The result is shown for one
// cycle under rsp_valid; the receiver cannot stall it.
module near_duplicate_point_counter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [ndpc_pkg::TolBits-1:0]  csr_wr_data,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_type,
   input  wire logic                          req_start_new,
   input  wire logic signed [ndpc_pkg::CoordBits-1:0] req_coord_x,
   input  wire logic signed [ndpc_pkg::CoordBits-1:0] req_coord_y,
   input  wire logic signed [ndpc_pkg::CoordBits-1:0] req_coord_z,
   output logic                               rsp_valid,
   output logic [ndpc_pkg::PairBits-1:0]      rsp_pair_count,
   output logic [ndpc_pkg::OutCntBits-1:0]    rsp_vertex_count,
   output logic [ndpc_pkg::OutCntBits-1:0]    rsp_points_loaded,
   output logic                               rsp_overflow
);
   import ndpc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_PAIR, ST_DRAIN, ST_READ, ST_LAST, ST_DONE
   } state_type;

   state_type state_ff;
   logic [TolBits-1:0] tol_ff;
   logic [CntBits-1:0] count_ff;
   logic dropped_ff;
   logic [CntBits-1:0] i_ff, j_ff;
   logic cmp_ff;          // read data valid for a pair this cycle
   logic last_ff;         // the pair being scored closes its row
   logic [AddrBits-1:0] cb_ff;
   logic [PairBits-1:0] pairs_ff;
   logic [OutCntBits-1:0] verts_ff;
   logic row_hit_ff;
   logic mark_rd_ff;
   logic mark_mem [MaxPoints];

   logic accept, load_go, eval_go;
   logic [CntBits-1:0] base_count;
   logic wr_en;
   point_type wr_data, rd_a, rd_b;
   logic [CoordBits-1:0] dx, dy, dz;
   logic hit;
   logic clr_en, mark_wr_en, mark_wr_data;
   logic [AddrBits-1:0] mark_wr_addr;

   assign accept  = start && !busy;
   assign load_go = accept && (req_type == CMD_LOAD);
   assign eval_go = accept && (req_type == CMD_EVAL);
   assign base_count = req_start_new ? '0 : count_ff;
   assign wr_en = load_go && (base_count < CntBits'(MaxPoints));
   assign wr_data = '{x: to_biased(req_coord_x), y: to_biased(req_coord_y),
                      z: to_biased(req_coord_z)};

   ndpc_point_ram u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(base_count[AddrBits-1:0]),
      .wr_data(wr_data), .rd_addr_a(i_ff[AddrBits-1:0]), .rd_data_a(rd_a),
      .rd_addr_b(j_ff[AddrBits-1:0]), .rd_data_b(rd_b)
   );

   // Absolute differences of the pair read last cycle.
   assign dx = (rd_a.x >= rd_b.x) ? rd_a.x - rd_b.x : rd_b.x - rd_a.x;
   assign dy = (rd_a.y >= rd_b.y) ? rd_a.y - rd_b.y : rd_b.y - rd_a.y;
   assign dz = (rd_a.z >= rd_b.z) ? rd_a.z - rd_b.z : rd_b.z - rd_a.z;
   assign hit = cmp_ff && (dx <= CoordBits'(tol_ff)) && (dy <= CoordBits'(tol_ff))
                && (dz <= CoordBits'(tol_ff));

   // Mark bits record that a point has a partner of lower index. The clear
   // pass and the pair hits share the single write port.
   assign clr_en = (state_ff == ST_CLEAR) && (i_ff < count_ff);
   assign mark_wr_en = clr_en || hit;
   assign mark_wr_addr = clr_en ? i_ff[AddrBits-1:0] : cb_ff;
   assign mark_wr_data = !clr_en;

   // Mark memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mark_wr_en) begin
         mark_mem[mark_wr_addr] <= mark_wr_data;
      end
      mark_rd_ff <= mark_mem[i_ff[AddrBits-1:0]];
   end

   // Sequencer, set state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tol_ff <= '0;
         count_ff <= '0;
         dropped_ff <= 1'b0;
         cmp_ff <= 1'b0;
         row_hit_ff <= 1'b0;
         rsp_valid <= 1'b0;
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         rsp_valid <= 1'b0;
         cmp_ff <= 1'b0;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
         if (load_go) begin
            if (base_count < CntBits'(MaxPoints)) begin
               count_ff <= base_count + 1'b1;
               dropped_ff <= req_start_new ? 1'b0 : dropped_ff;
            end else begin
               count_ff <= base_count;
               dropped_ff <= 1'b1;
            end
         end
         // Score the pair read last cycle. When a row closes, its point is a
         // vertex if it had a partner of higher index in the row or of lower
         // index in an earlier row.
         if (cmp_ff) begin
            if (hit) begin
               pairs_ff <= pairs_ff + 1'b1;
            end
            if (last_ff) begin
               row_hit_ff <= 1'b0;
               if (row_hit_ff || hit || mark_rd_ff) begin
                  verts_ff <= verts_ff + 1'b1;
               end
            end else if (hit) begin
               row_hit_ff <= 1'b1;
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (eval_go) begin
                  i_ff <= '0;
                  state_ff <= ST_CLEAR;
               end
            end
            ST_CLEAR: begin
               if (i_ff < count_ff) begin
                  i_ff <= i_ff + 1'b1;
               end else begin
                  pairs_ff <= '0;
                  verts_ff <= '0;
                  i_ff <= '0;
                  j_ff <= CntBits'(1);
                  state_ff <= (count_ff > CntBits'(1)) ? ST_PAIR : ST_DONE;
               end
            end
            ST_PAIR: begin
               cmp_ff <= 1'b1;
               cb_ff <= j_ff[AddrBits-1:0];
               last_ff <= !(j_ff + 1'b1 < count_ff);
               if (j_ff + 1'b1 < count_ff) begin
                  j_ff <= j_ff + 1'b1;
               end else if (i_ff + CntBits'(2) < count_ff) begin
                  i_ff <= i_ff + 1'b1;
                  j_ff <= i_ff + CntBits'(2);
               end else begin
                  i_ff <= count_ff - 1'b1;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               // The last pair is scored and may mark the last point.
               state_ff <= ST_READ;
            end
            ST_READ: begin
               // The mark of the last point is read after that write.
               state_ff <= ST_LAST;
            end
            ST_LAST: begin
               if (mark_rd_ff) begin
                  verts_ff <= verts_ff + 1'b1;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               rsp_valid <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_pair_count = pairs_ff;
   assign rsp_vertex_count = verts_ff;
   assign rsp_points_loaded = OutCntBits'(count_ff);
   assign rsp_overflow = dropped_ff;
endmodule
`default_nettype wire

FILE: design/ndpc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ndpc_checker
// Port-level checks of the near-duplicate point counter.
// ----------------------------------------------------------------------------
module ndpc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_type,
   input wire logic rsp_valid,
   input wire logic [ndpc_pkg::OutCntBits-1:0] rsp_vertex_count,
   input wire logic [ndpc_pkg::OutCntBits-1:0] rsp_points_loaded
);
   // An accepted evaluate word makes the block busy.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type |=> busy) else $error("evaluate not busy");
   // A result only comes while busy, and ends it.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy) else $error("stray result");
   // A load word never makes the block busy.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_type |=> !busy) else $error("load set busy");
   // Vertices never exceed the points loaded.
   a_verts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_vertex_count <= rsp_points_loaded) else $error("vertex count");
endmodule

bind near_duplicate_point_counter ndpc_checker u_ndpc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_type(req_type),
   .rsp_valid(rsp_valid),
   .rsp_vertex_count(rsp_vertex_count), .rsp_points_loaded(rsp_points_loaded)
);
`default_nettype wire

FILE: sim/tb_near_duplicate_point_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_near_duplicate_point_counter
// Self-checking bench for the near-duplicate point counter. A short table of
// directed words covers the coordinate extremes, the tolerance extremes and
// empty and single-point sets. Random point sets follow, mostly clustered so
// that many pairs fall within tolerance. Each evaluate result is checked
// against an in-bench count of close pairs, or against a tally typed in the table.
// ----------------------------------------------------------------------------
module tb_near_duplicate_point_counter;
   import ndpc_pkg::*;

   typedef enum int {ROW_LOAD, ROW_EVAL, ROW_CSR} row_kind_type;

   typedef struct {
      logic [PairBits-1:0]   pairs;
      logic [OutCntBits-1:0] verts;
      logic [OutCntBits-1:0] loaded;
      logic                  ovf;
   } tally_type;

   typedef struct {
      row_kind_type                 kind;
      logic                         fresh;
      logic signed [CoordBits-1:0]  x, y, z;
      logic [TolBits-1:0]           tol;
      bit                           typed;
      tally_type                    want;
   } row_type;

   localparam logic signed [CoordBits-1:0] CMax = 32'sh7FFF_FFFF;
   localparam logic signed [CoordBits-1:0] CMin = 32'sh8000_0000;
   localparam logic [TolBits-1:0] TolMax = 31'h7FFF_FFFF;
   localparam int WatchLimit = 20_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [TolBits-1:0] csr_wr_data = '0;
   logic start = 1'b0;
   logic busy;
   logic req_type = CMD_LOAD;
   logic req_start_new = 1'b0;
   logic signed [CoordBits-1:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic rsp_valid;
   logic [PairBits-1:0] rsp_pair_count;
   logic [OutCntBits-1:0] rsp_vertex_count, rsp_points_loaded;
   logic rsp_overflow;

   // Typed expectation travels with the word that carries it.
   logic typed_now = 1'b0;
   tally_type typed_want;

   near_duplicate_point_counter DUT (
      .clock, .reset, .csr_wr_en, .csr_wr_data, .start, .busy,
      .req_type, .req_start_new, .req_coord_x, .req_coord_y, .req_coord_z,
      .rsp_valid, .rsp_pair_count, .rsp_vertex_count, .rsp_points_loaded,
      .rsp_overflow
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Shadow copy of the point store and settings.
   logic signed [CoordBits-1:0] shadow_x[MaxPoints];
   logic signed [CoordBits-1:0] shadow_y[MaxPoints];
   logic signed [CoordBits-1:0] shadow_z[MaxPoints];
   int unsigned shadow_count = 0;
   bit shadow_dropped = 1'b0;
   logic [TolBits-1:0] shadow_tol = '0;

   tally_type pending_tallies[$];
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned words_sent = 0;
   bit gaps_on = 1'b1;

   function automatic bit near_axis(logic signed [CoordBits-1:0] a,
                                    logic signed [CoordBits-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d <= longint'(shadow_tol);
   endfunction

   // Counts every close pair; the sweep order cannot change the totals.
   function automatic tally_type count_close_pairs();
      tally_type t;
      bit marked[MaxPoints];
      longint npairs;
      int nverts;
      npairs = 0;
      nverts = 0;
      for (int i = 0; i < MaxPoints; i++) marked[i] = 1'b0;
      for (int i = 0; i < int'(shadow_count); i++) begin
         for (int j = i + 1; j < int'(shadow_count); j++) begin
            if (near_axis(shadow_x[i], shadow_x[j]) && near_axis(shadow_y[i], shadow_y[j])
                && near_axis(shadow_z[i], shadow_z[j])) begin
               npairs++;
               if (!marked[i]) begin marked[i] = 1'b1; nverts++; end
               if (!marked[j]) begin marked[j] = 1'b1; nverts++; end
            end
         end
      end
      t.pairs = npairs[PairBits-1:0];
      t.verts = nverts[OutCntBits-1:0];
      t.loaded = shadow_count[OutCntBits-1:0];
      t.ovf = shadow_dropped;
      return t;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Track accepted words, register writes and results.
   always @(posedge clock) begin
      tally_type t;
      if (!reset) begin
         if (csr_wr_en) shadow_tol = csr_wr_data;
         if (start && !busy) begin
            if (req_type == CMD_LOAD) begin
               if (req_start_new) begin
                  shadow_count = 0;
                  shadow_dropped = 1'b0;
               end
               if (shadow_count >= MaxPoints) begin
                  shadow_dropped = 1'b1;
               end else begin
                  shadow_x[shadow_count] = req_coord_x;
                  shadow_y[shadow_count] = req_coord_y;
                  shadow_z[shadow_count] = req_coord_z;
                  shadow_count++;
               end
            end else begin
               t = count_close_pairs();
               if (typed_now) t = typed_want;
               pending_tallies.push_back(t);
            end
         end
         if (rsp_valid) begin
            if (pending_tallies.size() == 0) begin
               report_mismatch("unexpected result word, pair_count", rsp_pair_count, 0);
            end else begin
               t = pending_tallies.pop_front();
               if (rsp_pair_count !== t.pairs)
                  report_mismatch("pair_count", rsp_pair_count, t.pairs);
               if (rsp_vertex_count !== t.verts)
                  report_mismatch("vertex_count", rsp_vertex_count, t.verts);
               if (rsp_points_loaded !== t.loaded)
                  report_mismatch("points_loaded", rsp_points_loaded, t.loaded);
               if (rsp_overflow !== t.ovf)
                  report_mismatch("overflow", rsp_overflow, t.ovf);
            end
         end
      end
   end

   // Watchdog on cycles with no traffic at all.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one word and hold it until accepted.
   task automatic send_word(logic cmd, logic fresh, logic signed [CoordBits-1:0] x,
                            logic signed [CoordBits-1:0] y,
                            logic signed [CoordBits-1:0] z, bit typed, tally_type want);
      if (gaps_on && $urandom_range(0, 99) < 31) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= cmd;
      req_start_new <= fresh;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      typed_now <= typed;
      typed_want <= want;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   // Wait for the block to drain, then write the tolerance.
   task automatic write_tolerance(logic [TolBits-1:0] tol);
      start <= 1'b0;
      do @(posedge clock); while (pending_tallies.size() != 0 || busy);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= tol;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_point(logic fresh, logic signed [CoordBits-1:0] x,
                             logic signed [CoordBits-1:0] y,
                             logic signed [CoordBits-1:0] z);
      tally_type none;
      none = '{default: '0};
      send_word(CMD_LOAD, fresh, x, y, z, 1'b0, none);
   endtask

   task automatic evaluate_set();
      tally_type none;
      none = '{default: '0};
      send_word(CMD_EVAL, 1'b0, $urandom, $urandom, $urandom, 1'b0, none);
   endtask

   function automatic logic signed [CoordBits-1:0] near_coord(
         logic signed [CoordBits-1:0] base, int unsigned span);
      return base + $signed($urandom_range(0, 2 * span)) - $signed(span);
   endfunction

   row_type rows[$];

   function automatic row_type mk(row_kind_type k, logic fresh,
                                  logic signed [CoordBits-1:0] x,
                                  logic signed [CoordBits-1:0] y,
                                  logic signed [CoordBits-1:0] z, logic [TolBits-1:0] tol,
                                  bit typed, tally_type want);
      row_type r;
      r.kind = k; r.fresh = fresh; r.x = x; r.y = y; r.z = z; r.tol = tol;
      r.typed = typed; r.want = want;
      return r;
   endfunction

   initial begin
      tally_type nil;
      logic signed [CoordBits-1:0] bx, by, bz, lx, ly, lz;
      int unsigned span, n;
      nil = '{default: '0};

      // Directed table: extremes, tolerance edges, tiny sets.
      rows.push_back(mk(ROW_EVAL, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0}));
      rows.push_back(mk(ROW_CSR, 0, 0, 0, 0, '0, 0, nil));
      rows.push_back(mk(ROW_LOAD, 1, CMax, CMax, CMax, 0, 0, nil));
      rows.push_back(mk(ROW_EVAL, 0, 0, 0, 0, 0, 1, '{0, 0, 1, 0}));
      rows.push_back(mk(ROW_LOAD, 0, CMin, CMin, CMin, 0, 0, nil));
      rows.push_back(mk(ROW_LOAD, 0, CMax, CMax, CMax, 0, 0, nil));
      rows.push_back(mk(ROW_EVAL, 0, 0, 0, 0, 0, 1, '{1, 2, 3, 0}));
      rows.push_back(mk(ROW_CSR, 0, 0, 0, 0, TolMax, 0, nil));
      rows.push_back(mk(ROW_EVAL, 0, 0, 0, 0, 0, 0, nil));
      rows.push_back(mk(ROW_LOAD, 1, 0, 0, 0, 0, 0, nil));
      rows.push_back(mk(ROW_LOAD, 0, CMax, 0, -1, 0, 0, nil));
      rows.push_back(mk(ROW_LOAD, 0, -1, CMin + 1, 0, 0, 0, nil));
      rows.push_back(mk(ROW_LOAD, 0, CMin, 0, 0, 0, 0, nil));
      rows.push_back(mk(ROW_EVAL, 0, 0, 0, 0, 0, 0, nil));
      rows.push_back(mk(ROW_CSR, 0, 0, 0, 0, 31'd1, 0, nil));
      rows.push_back(mk(ROW_LOAD, 1, 5, 0, 0, 0, 0, nil));
      rows.push_back(mk(ROW_LOAD, 0, 5, 1, -1, 0, 0, nil));
      rows.push_back(mk(ROW_LOAD, 0, 6, 0, 0, 0, 0, nil));
      rows.push_back(mk(ROW_LOAD, 0, 4, 2, 0, 0, 0, nil));
      rows.push_back(mk(ROW_LOAD, 0, 5, 0, 2, 0, 0, nil));
      rows.push_back(mk(ROW_EVAL, 0, 0, 0, 0, 0, 0, nil));
      rows.push_back(mk(ROW_EVAL, 0, 0, 0, 0, 0, 0, nil));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         case (rows[i].kind)
            ROW_CSR: begin
               write_tolerance(rows[i].tol);
            end
            ROW_LOAD: begin
               send_word(CMD_LOAD, rows[i].fresh, rows[i].x, rows[i].y, rows[i].z,
                         1'b0, nil);
            end
            default: begin
               send_word(CMD_EVAL, 1'b0, rows[i].x, rows[i].y, rows[i].z,
                         rows[i].typed, rows[i].want);
            end
         endcase
      end

      // Random sets, mostly clustered around a base point.
      while (words_sent < 1000) begin
         gaps_on = !(words_sent >= 300 && words_sent < 500);
         case ($urandom_range(0, 4))
            0: write_tolerance('0);
            1: write_tolerance(TolMax);
            2: write_tolerance(TolBits'($urandom_range(0, 31'h3_FFFF)));
            default: write_tolerance(TolBits'($urandom));
         endcase
         repeat ($urandom_range(2, 6)) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            span = (shadow_tol > 31'h10_0000) ? 32'h20_0000 : shadow_tol + 2;
            bx = $urandom; by = $urandom; bz = $urandom;
            lx = bx; ly = by; lz = bz;
            for (int k = 0; k < int'(n); k++) begin
               case ($urandom_range(0, 9))
                  0: begin lx = $urandom; ly = $urandom; lz = $urandom; end
                  1: ;
                  2: begin lx = CMax; ly = CMin; lz = CMax; end
                  default: begin
                     lx = near_coord(bx, span);
                     ly = near_coord(by, span);
                     lz = near_coord(bz, span);
                  end
               endcase
               // Now and then append to the old set instead of starting over.
               load_point(k == 0 && $urandom_range(0, 9) != 0, lx, ly, lz);
            end
            evaluate_set();
            if ($urandom_range(0, 3) == 0) evaluate_set();
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (pending_tallies.size() != 0 || busy);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_tallies.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
